[hdl/mpq_pkg.sv]
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the sorted max priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int DEFAULT_CAPACITY = 16;
	localparam int VALUE_W          = 32;
	localparam int COUNT_W          = 5;

	// opcode field
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    do_insert;
		logic    do_remove;
		logic    load;
		status_t code;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
	} sts_t;

endpackage

[hdl/mpq_ctrl.sv]
// ----------------------------------------------------------------------------
// mpq_ctrl
// Handshake controller: accepts transactions, decodes them against the
// queue flags and keeps the result register's valid state.
// ----------------------------------------------------------------------------
module mpq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          opcode,
	output logic          out_valid,
	input  logic          out_stall,
	input  mpq_pkg::sts_t sts,
	output mpq_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_HOLD = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall  = (state_q == S_HOLD) && out_stall;
	assign out_valid = (state_q == S_HOLD);
	assign accept    = in_valid && !in_stall;

	always_comb begin
		cmd.do_insert = 1'b0;
		cmd.do_remove = 1'b0;
		cmd.load      = accept;
		cmd.code      = mpq_pkg::ST_OK;
		if (accept) begin
			if (opcode == mpq_pkg::OP_DEQ) begin
				if (sts.empty) begin
					cmd.code = mpq_pkg::ST_EMPTY;
				end else begin
					cmd.do_remove = 1'b1;
				end
			end else begin
				if (sts.full) begin
					cmd.code = mpq_pkg::ST_FULL;
				end else begin
					cmd.do_insert = 1'b1;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_HOLD;
			end
			S_HOLD: begin
				// result taken with no new transaction behind it
				if (!out_stall && !accept) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/mpq_dp.sv]
// ----------------------------------------------------------------------------
// mpq_dp
// Sorted row of entry registers (largest first), occupancy counter and
// result register. Each cell compares against the new value in parallel.
// ----------------------------------------------------------------------------
module mpq_dp #(
	parameter int CAPACITY = mpq_pkg::DEFAULT_CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mpq_pkg::cmd_t                       cmd,
	input  logic signed [mpq_pkg::VALUE_W-1:0]  value,
	output mpq_pkg::sts_t                       sts,
	output logic signed [mpq_pkg::VALUE_W-1:0]  result_value,
	output logic [1:0]                          status,
	output logic [mpq_pkg::COUNT_W-1:0]         count
);

	localparam int OccW = $clog2(CAPACITY + 1);

	logic signed [mpq_pkg::VALUE_W-1:0] entries_q [CAPACITY];
	logic signed [mpq_pkg::VALUE_W-1:0] entries_d [CAPACITY];
	logic [CAPACITY-1:0]                ge;
	logic [OccW-1:0]                    occ_q;
	logic [OccW-1:0]                    occ_d;
	logic [OccW+mpq_pkg::COUNT_W-1:0]   occ_ext;
	logic signed [mpq_pkg::VALUE_W-1:0] result_q;
	mpq_pkg::status_t                   status_q;
	logic [mpq_pkg::COUNT_W-1:0]        count_q;

	assign sts.full  = (occ_q == OccW'(CAPACITY));
	assign sts.empty = (occ_q == '0);

	// ge is a prefix mask: cells holding values >= the new one stay put
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
		assign ge[i] = (occ_q > OccW'(i)) && (entries_q[i] >= value);
	end

	// insert: cells past the prefix take the new value once, then shift down
	// remove: every cell but the last takes its lower neighbor; the last keeps its value
	for (genvar i = 0; i < CAPACITY; i++) begin : g_next
		logic signed [mpq_pkg::VALUE_W-1:0] ins_val;
		logic signed [mpq_pkg::VALUE_W-1:0] rem_val;
		if (i == 0) begin : g_head
			assign ins_val = ge[i] ? entries_q[i] : value;
		end else begin : g_body
			assign ins_val = ge[i]   ? entries_q[i] :
			                 ge[i-1] ? value : entries_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign rem_val = entries_q[i];
		end else begin : g_link
			assign rem_val = entries_q[i+1];
		end
		assign entries_d[i] = cmd.do_insert ? ins_val :
		                      cmd.do_remove ? rem_val : entries_q[i];
	end

	always_comb begin
		occ_d = occ_q;
		if (cmd.do_insert) occ_d = occ_q + OccW'(1);
		else if (cmd.do_remove) occ_d = occ_q - OccW'(1);
	end

	assign occ_ext = {{mpq_pkg::COUNT_W{1'b0}}, occ_d};

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			entries_q[i] <= entries_d[i];
		end
		if (cmd.load) begin
			result_q <= cmd.do_remove ? entries_q[0] : '0;
			status_q <= cmd.code;
			count_q  <= occ_ext[mpq_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_d;
		end
	end

	assign result_value = result_q;
	assign status       = status_q;
	assign count        = count_q;

endmodule

[hdl/max_priority_queue.sv]
// ----------------------------------------------------------------------------
// max_priority_queue
// Bounded max priority queue of signed 32-bit values, kept sorted.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries opcode and value: opcode
//   OP_ENQ inserts value, OP_DEQ removes and returns the largest entry.
//   Output channel (out_valid / out_stall) returns one transaction per
//   input: result_value, status (ok, dequeue on empty, enqueue on full)
//   and count, the occupancy after the operation (low 5 bits).
//   The result is registered and valid in the cycle after accept.
//   Throughput is one transaction per cycle while the receiver does not stall; every cell of the sorted row
//   compares against the new value at once and the row shifts in one step.
//   When the receiver stalls with a result pending, in_stall rises and the
//   result register holds; a new transaction is taken in the same cycle
//   the pending result is taken.
//   Reset empties the queue at once (occupancy cleared); there is no
//   clearing pass. Enqueue on a full queue and dequeue on an empty one
//   leave the queue unchanged.
// ----------------------------------------------------------------------------
module max_priority_queue #(
	parameter int CAPACITY = mpq_pkg::DEFAULT_CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic signed [mpq_pkg::VALUE_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [mpq_pkg::VALUE_W-1:0]  result_value,
	output logic [1:0]                          status,
	output logic [mpq_pkg::COUNT_W-1:0]         count
);

	mpq_pkg::cmd_t cmd;
	mpq_pkg::sts_t sts;

	mpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mpq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.sts          (sts),
		.result_value (result_value),
		.status       (status),
		.count        (count)
	);

endmodule
